### src/pwh_pkg.sv
// package for the pilot-wire heater mode driver: types, constants, band decode
`timescale 1ns / 1ps

package pwh_pkg;

  localparam int CHANNELS_DEF = 8;

  localparam int MODE_W = 7;
  localparam int PERIOD_W = 16;
  localparam int PULSE_W = 8;
  localparam int COUNT_W = 4;
  localparam int LEVELS_W = 8;
  localparam int ADDR_W = 4;
  localparam int DATA_W = 32;

  localparam logic [COUNT_W-1:0] CHANNEL_COUNT_RST = 4'd8;
  localparam logic [PERIOD_W-1:0] INTERVAL_RST = 16'd300;
  localparam logic [PULSE_W-1:0] LONG_PULSE_RST = 8'd7;
  localparam logic [PULSE_W-1:0] SHORT_PULSE_RST = 8'd3;

  localparam logic [MODE_W-1:0] STOP_MAX = 7'd10;
  localparam logic [MODE_W-1:0] FROST_MAX = 7'd20;
  localparam logic [MODE_W-1:0] ECO_MAX = 7'd30;
  localparam logic [MODE_W-1:0] COMFORT2_MAX = 7'd40;
  localparam logic [MODE_W-1:0] COMFORT1_MAX = 7'd50;

  typedef enum logic [1:0] {
    REG_CHANNEL_COUNT = 2'd0,
    REG_INTERVAL = 2'd1,
    REG_LONG_PULSE = 2'd2,
    REG_SHORT_PULSE = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    BAND_STOP = 3'd0,
    BAND_FROST = 3'd1,
    BAND_ECO = 3'd2,
    BAND_COMFORT2 = 3'd3,
    BAND_COMFORT1 = 3'd4,
    BAND_COMFORT = 3'd5
  } band_t;

  typedef enum logic {
    OP_SET = 1'b0,
    OP_TICK = 1'b1
  } opcode_t;

  typedef struct packed {
    logic [MODE_W-1:0] mode;
    logic [PERIOD_W-1:0] period;
    logic [PULSE_W-1:0] pulse;
    logic pos;
    logic neg;
  } chan_st_t;

  typedef struct packed {
    logic tick;
    logic [MODE_W-1:0] mode;
    logic force_req;
  } chan_cmd_t;

  typedef struct packed {
    logic [PERIOD_W-1:0] interval;
    logic [PULSE_W-1:0] long_pulse;
    logic [PULSE_W-1:0] short_pulse;
  } chan_cfg_t;

  function automatic band_t band_of(input logic [MODE_W-1:0] v);
    band_t b;
    if (v <= STOP_MAX) b = BAND_STOP;
    else if (v <= FROST_MAX) b = BAND_FROST;
    else if (v <= ECO_MAX) b = BAND_ECO;
    else if (v <= COMFORT2_MAX) b = BAND_COMFORT2;
    else if (v <= COMFORT1_MAX) b = BAND_COMFORT1;
    else b = BAND_COMFORT;
    return b;
  endfunction

endpackage

### src/pwh_chan_unit.sv
// shared per-channel update unit: set command or one tick of one channel
`timescale 1ns / 1ps

module pwh_chan_unit import pwh_pkg::*; (
  input  chan_st_t  st,
  input  chan_cmd_t cmd,
  input  chan_cfg_t cfg,
  output chan_st_t  st_next,
  output logic      changed
);

  band_t old_band;
  band_t new_band;
  logic [PERIOD_W-1:0] period_inc;
  logic [PULSE_W-1:0] pulse_len;

  assign old_band = band_of(st.mode);
  assign new_band = band_of(cmd.mode);
  assign period_inc = st.period + 16'd1;
  assign pulse_len = (old_band == BAND_COMFORT2) ? cfg.long_pulse : cfg.short_pulse;

  always_comb begin
    st_next = st;
    changed = 1'b0;
    if (cmd.tick) begin
      if (st.pulse != '0) begin
        st_next.pulse = st.pulse - 8'd1;
        if (st.pulse == 8'd1) begin
          st_next.pos = 1'b1;
          st_next.neg = 1'b1;
        end
      end
      if (old_band == BAND_COMFORT2 || old_band == BAND_COMFORT1) begin
        if (period_inc == cfg.interval) begin
          st_next.period = '0;
          if (pulse_len != '0) begin
            st_next.pulse = pulse_len;
            st_next.pos = 1'b0;
            st_next.neg = 1'b0;
          end
        end else begin
          st_next.period = period_inc;
        end
      end
    end else if (st.mode != cmd.mode || cmd.force_req) begin
      changed = 1'b1;
      st_next.mode = cmd.mode;
      if (old_band != new_band || cmd.force_req) begin
        st_next.period = '0;
        st_next.pulse = '0;
        unique case (new_band)
          BAND_STOP: begin
            st_next.pos = 1'b0;
            st_next.neg = 1'b1;
          end
          BAND_FROST: begin
            st_next.pos = 1'b1;
            st_next.neg = 1'b0;
          end
          BAND_ECO: begin
            st_next.pos = 1'b0;
            st_next.neg = 1'b0;
          end
          default: begin
            st_next.pos = 1'b1;
            st_next.neg = 1'b1;
          end
        endcase
      end
    end
  end

endmodule

### src/pilot_wire_heater_mode_driver_unit.sv
// top level of the pilot-wire heater mode driver: sequencer, channel state, config port
`timescale 1ns / 1ps

// Drives a positive and a negative pilot-wire line for each heater channel. Each item
// is a set command or a tick and yields one result holding all line levels.
// A set command's result is loaded into the output register after the capture and
// update steps; a tick's result is loaded after one shared channel update unit has
// visited the fitted channels (the effective channel count) one per cycle and a final
// step has ended the sweep. The next item is accepted only once the result is loaded.
// Input stall stays high from acceptance until the result is loaded; while an earlier
// result waits in the output register the next item is still taken and processed, and
// its own result then waits, with input stall high, until the output register frees.

module pilot_wire_heater_mode_driver_unit import pwh_pkg::*; #(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  output logic [DATA_W-1:0]   prdata,
  output logic                pready,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                opcode,
  input  logic [2:0]          channel,
  input  logic [MODE_W-1:0]   mode_value,
  input  logic                force_req,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEVELS_W-1:0] positive_levels,
  output logic [LEVELS_W-1:0] negative_levels,
  output logic                stored_changed
);

  localparam int IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam logic [4:0] CH5 = 5'(CHANNELS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SET  = 4'b0010,
    S_TICK = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  state_t state;
  logic [COUNT_W-1:0] cnt;

  logic [COUNT_W-1:0] channel_count;
  logic [PERIOD_W-1:0] interval_ticks;
  logic [PULSE_W-1:0] long_pulse_ticks;
  logic [PULSE_W-1:0] short_pulse_ticks;

  logic [MODE_W-1:0] mode_store [CHANNELS];
  logic [PERIOD_W-1:0] period_count [CHANNELS];
  logic [PULSE_W-1:0] pulse_count [CHANNELS];
  logic [CHANNELS-1:0] positive_line;
  logic [CHANNELS-1:0] negative_line;

  logic [2:0] ch_r;
  logic [MODE_W-1:0] mode_r;
  logic force_r;
  logic changed_r;

  logic [COUNT_W-1:0] n_eff;
  logic set_hit;
  logic tick_go;
  logic [7:0] ch_ext;
  logic [IDX_W-1:0] idx;
  logic in_accept;
  logic out_load;
  logic cfg_write;
  logic [15:0] pos_ext;
  logic [15:0] neg_ext;

  chan_st_t st;
  chan_st_t st_next;
  chan_cmd_t cmd;
  chan_cfg_t ccfg;
  logic unit_changed;

  assign n_eff = (5'(channel_count) > CH5) ? CH5[COUNT_W-1:0] : channel_count;
  assign set_hit = (state == S_SET) && (4'(ch_r) < n_eff);
  assign tick_go = (state == S_TICK) && (cnt < n_eff);
  assign ch_ext = {5'd0, ch_r};
  assign idx = (state == S_SET) ? ch_ext[IDX_W-1:0] : cnt[IDX_W-1:0];

  assign in_stall = (state != S_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_load = (state == S_DONE) && (!out_valid || !out_stall);

  assign st.mode = mode_store[idx];
  assign st.period = period_count[idx];
  assign st.pulse = pulse_count[idx];
  assign st.pos = positive_line[idx];
  assign st.neg = negative_line[idx];

  assign cmd.tick = (state == S_TICK);
  assign cmd.mode = mode_r;
  assign cmd.force_req = force_r;

  assign ccfg.interval = interval_ticks;
  assign ccfg.long_pulse = long_pulse_ticks;
  assign ccfg.short_pulse = short_pulse_ticks;

  pwh_chan_unit u_chan (
    .st      (st),
    .cmd     (cmd),
    .cfg     (ccfg),
    .st_next (st_next),
    .changed (unit_changed)
  );

  // config port
  assign pready = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      channel_count <= CHANNEL_COUNT_RST;
      interval_ticks <= INTERVAL_RST;
      long_pulse_ticks <= LONG_PULSE_RST;
      short_pulse_ticks <= SHORT_PULSE_RST;
    end else if (cfg_write) begin
      unique case (reg_idx_t'(paddr[3:2]))
        REG_CHANNEL_COUNT: channel_count <= pwdata[COUNT_W-1:0];
        REG_INTERVAL: interval_ticks <= pwdata[PERIOD_W-1:0];
        REG_LONG_PULSE: long_pulse_ticks <= pwdata[PULSE_W-1:0];
        REG_SHORT_PULSE: short_pulse_ticks <= pwdata[PULSE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[3:2]))
      REG_CHANNEL_COUNT: prdata = 32'(channel_count);
      REG_INTERVAL: prdata = 32'(interval_ticks);
      REG_LONG_PULSE: prdata = 32'(long_pulse_ticks);
      REG_SHORT_PULSE: prdata = 32'(short_pulse_ticks);
      default: prdata = '0;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      changed_r <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_accept) begin
            cnt <= '0;
            changed_r <= 1'b0;
            state <= (opcode_t'(opcode) == OP_TICK) ? S_TICK : S_SET;
          end
        end
        S_SET: begin
          changed_r <= set_hit && unit_changed;
          state <= S_DONE;
        end
        S_TICK: begin
          if (tick_go) cnt <= cnt + 4'd1;
          else state <= S_DONE;
        end
        S_DONE: begin
          if (out_load) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      ch_r <= channel;
      mode_r <= mode_value;
      force_r <= force_req;
    end
  end

  // channel state
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < CHANNELS; i++) begin
        mode_store[i] <= '0;
        period_count[i] <= '0;
        pulse_count[i] <= '0;
      end
      positive_line <= '0;
      negative_line <= '0;
    end else if (set_hit || tick_go) begin
      mode_store[idx] <= st_next.mode;
      period_count[idx] <= st_next.period;
      pulse_count[idx] <= st_next.pulse;
      positive_line[idx] <= st_next.pos;
      negative_line[idx] <= st_next.neg;
    end
  end

  // output register
  assign pos_ext = 16'(positive_line);
  assign neg_ext = 16'(negative_line);

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      positive_levels <= pos_ext[LEVELS_W-1:0];
      negative_levels <= neg_ext[LEVELS_W-1:0];
      stored_changed <= changed_r;
    end
  end

  a_tick_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |-> (cnt <= n_eff))
    else $error("tick sweep ran past the fitted channels");

  a_load_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (out_valid && state == S_IDLE))
    else $error("finished item did not reach the output register");

  a_tick_no_change: assert property (@(posedge clk) disable iff (rst)
    (state == S_TICK) |=> !changed_r)
    else $error("tick item flagged a stored mode change");

  a_one_update: assert property (@(posedge clk) disable iff (rst)
    !(set_hit && tick_go))
    else $error("set and tick update in the same cycle");

endmodule

### verif/heater_line_checker.sv
// checker for the pilot-wire heater driver: tracks config writes, predicts line levels, compares results
`timescale 1ns / 1ps

module heater_line_checker import pwh_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic                pready,
  input  logic [ADDR_W-1:0]   paddr,
  input  logic [DATA_W-1:0]   pwdata,
  input  logic                in_valid,
  input  logic                in_stall,
  input  logic                opcode,
  input  logic [2:0]          channel,
  input  logic [MODE_W-1:0]   mode_value,
  input  logic                force_req,
  input  logic                out_valid,
  input  logic                out_stall,
  input  logic [LEVELS_W-1:0] positive_levels,
  input  logic [LEVELS_W-1:0] negative_levels,
  input  logic                stored_changed,
  output int                  fail_count,
  output int                  pending
);

  typedef struct packed {
    logic [LEVELS_W-1:0] pos;
    logic [LEVELS_W-1:0] neg;
    logic                changed;
  } line_levels_t;

  logic [COUNT_W-1:0]  cfg_count;
  logic [PERIOD_W-1:0] cfg_interval;
  logic [PULSE_W-1:0]  cfg_long;
  logic [PULSE_W-1:0]  cfg_short;

  logic [MODE_W-1:0]   mode_q [CHANNELS_DEF];
  logic [PERIOD_W-1:0] period_q [CHANNELS_DEF];
  logic [PULSE_W-1:0]  pulse_q [CHANNELS_DEF];
  logic [LEVELS_W-1:0] pos_q;
  logic [LEVELS_W-1:0] neg_q;

  line_levels_t expected_levels [$];
  line_levels_t wanted;

  initial begin
    fail_count = 0;
    pending = 0;
  end

  function automatic band_t band_for_mode(input logic [MODE_W-1:0] v);
    int tens;
    tens = (v == '0) ? 0 : (int'(v) - 1) / 10;
    if (tens > 5) tens = 5;
    return band_t'(tens);
  endfunction

  function automatic int fitted_channels();
    return (int'(cfg_count) > CHANNELS_DEF) ? CHANNELS_DEF : int'(cfg_count);
  endfunction

  function automatic line_levels_t apply_heater_command(input logic op, input logic [2:0] ch,
                                                       input logic [MODE_W-1:0] mv,
                                                       input logic fr);
    line_levels_t res;
    band_t b;
    logic [PULSE_W-1:0] len;
    int active;
    active = fitted_channels();
    res.changed = 1'b0;
    if (opcode_t'(op) == OP_SET) begin
      if (int'(ch) < active && (mode_q[ch] != mv || fr)) begin
        b = band_for_mode(mv);
        if (band_for_mode(mode_q[ch]) != b || fr) begin
          period_q[ch] = '0;
          pulse_q[ch] = '0;
          case (b)
            BAND_STOP: begin
              pos_q[ch] = 1'b0;
              neg_q[ch] = 1'b1;
            end
            BAND_FROST: begin
              pos_q[ch] = 1'b1;
              neg_q[ch] = 1'b0;
            end
            BAND_ECO: begin
              pos_q[ch] = 1'b0;
              neg_q[ch] = 1'b0;
            end
            default: begin
              pos_q[ch] = 1'b1;
              neg_q[ch] = 1'b1;
            end
          endcase
        end
        mode_q[ch] = mv;
        res.changed = 1'b1;
      end
    end else begin
      for (int c = 0; c < active; c++) begin
        b = band_for_mode(mode_q[c]);
        if (pulse_q[c] != '0) begin
          pulse_q[c] = pulse_q[c] - 8'd1;
          if (pulse_q[c] == '0) begin
            pos_q[c] = 1'b1;
            neg_q[c] = 1'b1;
          end
        end
        if (b == BAND_COMFORT2 || b == BAND_COMFORT1) begin
          period_q[c] = period_q[c] + 16'd1;
          if (period_q[c] == cfg_interval) begin
            period_q[c] = '0;
            len = (b == BAND_COMFORT2) ? cfg_long : cfg_short;
            if (len != '0) begin
              pulse_q[c] = len;
              pos_q[c] = 1'b0;
              neg_q[c] = 1'b0;
            end
          end
        end
      end
    end
    res.pos = pos_q;
    res.neg = neg_q;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input int seen, input int wanted_v);
    $display("%0t mismatch %s: got %0h, expected %0h", $time, what, seen, wanted_v);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      cfg_count = CHANNEL_COUNT_RST;
      cfg_interval = INTERVAL_RST;
      cfg_long = LONG_PULSE_RST;
      cfg_short = SHORT_PULSE_RST;
      for (int c = 0; c < CHANNELS_DEF; c++) begin
        mode_q[c] = '0;
        period_q[c] = '0;
        pulse_q[c] = '0;
      end
      pos_q = '0;
      neg_q = '0;
      expected_levels.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (reg_idx_t'(paddr[3:2]))
          REG_CHANNEL_COUNT: cfg_count = pwdata[COUNT_W-1:0];
          REG_INTERVAL:      cfg_interval = pwdata[PERIOD_W-1:0];
          REG_LONG_PULSE:    cfg_long = pwdata[PULSE_W-1:0];
          REG_SHORT_PULSE:   cfg_short = pwdata[PULSE_W-1:0];
          default: ;
        endcase
      end
      if (out_valid && !out_stall) begin
        if (expected_levels.size() == 0) begin
          report_mismatch("unexpected item", {positive_levels, negative_levels}, 0);
        end else begin
          wanted = expected_levels.pop_front();
          if (positive_levels !== wanted.pos)
            report_mismatch("positive_levels", positive_levels, wanted.pos);
          if (negative_levels !== wanted.neg)
            report_mismatch("negative_levels", negative_levels, wanted.neg);
          if (stored_changed !== wanted.changed)
            report_mismatch("stored_changed", stored_changed, wanted.changed);
        end
      end
      if (in_valid && !in_stall)
        expected_levels.push_back(apply_heater_command(opcode, channel, mode_value, force_req));
    end
    pending <= expected_levels.size();
  end

endmodule

### verif/tb_top.sv
// testbench top for the pilot-wire heater driver: clock, reset, config writes, item stimulus, verdict
`timescale 1ns / 1ps

module tb_top;
  import pwh_pkg::*;

  localparam int RUN_LIMIT = 500000;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 160;

  logic                clk;
  logic                rst = 1'b1;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic                opcode = 1'b0;
  logic [2:0]          channel = '0;
  logic [MODE_W-1:0]   mode_value = '0;
  logic                force_req = 1'b0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [LEVELS_W-1:0] positive_levels;
  logic [LEVELS_W-1:0] negative_levels;
  logic                stored_changed;
  logic                steady = 1'b0;
  int                  fail_count;
  int                  pending;

  logic [MODE_W-1:0] boundary_modes [14] = '{7'd0, 7'd10, 7'd11, 7'd20, 7'd21, 7'd30, 7'd31,
                                            7'd40, 7'd41, 7'd50, 7'd51, 7'd99, 7'd100,
                                            7'd127};

  pilot_wire_heater_mode_driver_unit dut (.*);
  heater_line_checker checker_i (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // random backpressure, off during the steady stretch
  always @(posedge clk) begin
    if (rst || steady) out_stall <= 1'b0;
    else out_stall <= ($urandom_range(99) < 35);
  end

  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val, input int width,
                           input bit noisy);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= noisy ? (val | ($urandom << width)) : val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
  endtask

  task automatic program_config(input logic [COUNT_W-1:0] cc, input logic [PERIOD_W-1:0] iv,
                                input logic [PULSE_W-1:0] lp, input logic [PULSE_W-1:0] sp,
                                input bit noisy);
    write_reg(REG_CHANNEL_COUNT, cc, COUNT_W, noisy);
    write_reg(REG_INTERVAL, iv, PERIOD_W, noisy);
    write_reg(REG_LONG_PULSE, lp, PULSE_W, noisy);
    write_reg(REG_SHORT_PULSE, sp, PULSE_W, noisy);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic random_config(input bit noisy);
    logic [COUNT_W-1:0] cc;
    logic [PERIOD_W-1:0] iv;
    logic [PULSE_W-1:0] lp;
    logic [PULSE_W-1:0] sp;
    cc = ($urandom_range(99) < 65) ? 4'd8 : 4'($urandom_range(15));
    iv = ($urandom_range(99) < 85) ? 16'($urandom_range(1, 10)) : 16'($urandom);
    lp = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 6)) : 8'($urandom);
    sp = ($urandom_range(99) < 80) ? 8'($urandom_range(0, 6)) : 8'($urandom);
    program_config(cc, iv, lp, sp, noisy);
  endtask

  task automatic send_item(input opcode_t op, input logic [2:0] ch, input logic [MODE_W-1:0] mv,
                           input logic fr);
    while (!steady && $urandom_range(99) < 35) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    opcode <= op;
    channel <= ch;
    mode_value <= mv;
    force_req <= fr;
    do @(posedge clk); while (in_stall);
  endtask

  task automatic send_tick();
    send_item(OP_TICK, 3'($urandom), 7'($urandom), 1'($urandom));
  endtask

  task automatic send_random_item();
    int pick;
    logic [MODE_W-1:0] mv;
    pick = $urandom_range(99);
    if (pick < 55) mv = 7'($urandom_range(31, 50));
    else if (pick < 75) mv = boundary_modes[$urandom_range(13)];
    else mv = 7'($urandom);
    if ($urandom_range(99) < 45) send_item(OP_TICK, 3'($urandom), mv, 1'($urandom));
    else send_item(OP_SET, 3'($urandom), mv, $urandom_range(99) < 15);
  endtask

  // hold off new items until every result is back
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  initial begin
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < RUN_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // all bands, same-band change, force, pulses in both comfort bands
    program_config(4'd8, 16'd3, 8'd2, 8'd1, 1'b0);
    send_item(OP_SET, 3'd0, 7'd0, 1'b0);
    send_item(OP_SET, 3'd0, 7'd0, 1'b1);
    send_item(OP_SET, 3'd1, 7'd10, 1'b0);
    send_item(OP_SET, 3'd2, 7'd11, 1'b0);
    send_item(OP_SET, 3'd3, 7'd20, 1'b0);
    send_item(OP_SET, 3'd4, 7'd30, 1'b0);
    send_item(OP_SET, 3'd5, 7'd31, 1'b0);
    send_item(OP_SET, 3'd6, 7'd50, 1'b0);
    send_item(OP_SET, 3'd7, 7'd127, 1'b0);
    send_item(OP_SET, 3'd5, 7'd40, 1'b0);
    repeat (4) send_tick();
    send_item(OP_SET, 3'd6, 7'd45, 1'b1);
    send_item(OP_SET, 3'd7, 7'd99, 1'b0);
    repeat (2) send_tick();
    drain();

    // dropped channel, pulse not shorter than interval, zero pulse length
    program_config(4'd2, 16'd1, 8'd255, 8'd0, 1'b0);
    send_item(OP_SET, 3'd7, 7'd60, 1'b0);
    send_item(OP_SET, 3'd1, 7'd35, 1'b1);
    repeat (2) send_tick();
    send_item(OP_SET, 3'd0, 7'd41, 1'b0);
    send_tick();
    drain();

    // zero channels, zero interval
    program_config(4'd0, 16'd0, 8'd0, 8'd255, 1'b0);
    send_item(OP_SET, 3'd0, 7'd12, 1'b1);
    send_tick();
    drain();

    // channel count above the fitted maximum, widest interval
    program_config(4'd15, 16'd65535, 8'd255, 8'd255, 1'b0);
    send_item(OP_SET, 3'd7, 7'd33, 1'b0);
    send_tick();
    drain();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      random_config(p % 2 == 1);
      steady <= (p == 5);
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        if (p == 3 && k == PHASE_ITEMS / 2) drain();
        send_random_item();
      end
      drain();
    end
    steady <= 1'b0;

    repeat (16) @(posedge clk);
    if (fail_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

### files.f
src/pwh_pkg.sv
src/pwh_chan_unit.sv
src/pilot_wire_heater_mode_driver_unit.sv
verif/heater_line_checker.sv
verif/tb_top.sv
